FILE: hw/rtl/triangle_distance_color_blend_core_defines.svh
// Assertion macros for the triangle distance color blend core.
// Clock and reset names follow the core: i_clk, active low i_rst_n.
`ifndef TRIANGLE_DISTANCE_COLOR_BLEND_CORE_DEFINES_SVH
`define TRIANGLE_DISTANCE_COLOR_BLEND_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define TDCB_ASSERT(lbl, expr) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error("tdcb assertion failed");
`define TDCB_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("tdcb implication failed");
`define TDCB_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("tdcb next-cycle check failed");
`else
`define TDCB_ASSERT(lbl, expr)
`define TDCB_ASSERT_IMP(lbl, ante, cons)
`define TDCB_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

FILE: hw/rtl/tdcb_pkg.sv
package tdcb_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int FIELD_W    = 16;
    localparam int CHAN_W     = 8;
    localparam int COLOR_W    = 24;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_VERTEX_A = 3'd0,
        REG_VERTEX_B = 3'd1,
        REG_VERTEX_C = 3'd2,
        REG_COLOR_A  = 3'd3,
        REG_COLOR_B  = 3'd4,
        REG_COLOR_C  = 3'd5
    } t_cfg_reg;

endpackage

FILE: hw/rtl/tdcb_point_if.sv
interface tdcb_point_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] point_x;
    logic signed [15:0] point_y;

    modport source (output valid, point_x, point_y, input ready);
    modport sink   (input valid, point_x, point_y, output ready);
endinterface

FILE: hw/rtl/tdcb_color_if.sv
interface tdcb_color_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       clipped;
    logic       degenerate;

    modport source (output valid, red, green, blue, clipped, degenerate, input ready);
    modport sink   (input valid, red, green, blue, clipped, degenerate, output ready);
endinterface

FILE: hw/rtl/triangle_distance_color_blend_core.sv
// Blends three vertex colors by weight 1 - d/|AB| for one query point per request.
// Fully pipelined: a new point is taken every cycle while the result side accepts.
// Stages: differences, squares and squared distance, a bit-per-stage divider, a bit-per-stage
// square root, then weight (clamped at -2), products, channel sums and saturation to 8 bits.
// A stall on the result side holds the whole pipeline; nothing is dropped.
// Configuration writes must precede the first point that depends on them by one cycle.
`include "triangle_distance_color_blend_core_defines.svh"

module triangle_distance_color_blend_core #(
    parameter int COORD_WIDTH      = 16,
    parameter int WEIGHT_FRAC_BITS = 14
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    tdcb_point_if.sink                        i_point,
    tdcb_color_if.source                      o_color,
    input  logic                              i_cfg_we,
    input  logic [tdcb_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [tdcb_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import tdcb_pkg::*;

    localparam int CW  = (COORD_WIDTH < 16) ? COORD_WIDTH : 16;
    localparam int F   = WEIGHT_FRAC_BITS;
    localparam int SQW = 2 * CW;
    localparam int DW  = 2 * CW + 1;
    localparam int RW  = DW + 4;
    localparam int QW  = 2 * F + 4;
    localparam int SW  = F + 2;
    localparam int WW  = F + 3;
    localparam int PW  = F + 12;
    localparam int SMW = F + 14;
    localparam int NST = 3 + QW + SW + 4;

    localparam logic signed [WW-1:0] W_ONE = WW'(1) << F;
    localparam logic signed [WW-1:0] W_MIN = -(WW'(2) << F);

    // configuration
    logic [31:0]        r_vpos [3];
    logic [COLOR_W-1:0] r_col  [3];
    logic [SQW-1:0]     r_lsqx, r_lsqy;
    logic [DW-1:0]      r_l2;
    logic [DW+2:0]      r_l8;
    logic [DW+3:0]      r_l9;

    logic signed [CW:0]    ldx, ldy;
    logic signed [2*CW+1:0] lpx, lpy;
    logic [DW-1:0]         lsum;

    always_comb begin
        ldx  = {r_vpos[0][CW-1], r_vpos[0][CW-1:0]} - {r_vpos[1][CW-1], r_vpos[1][CW-1:0]};
        ldy  = {r_vpos[0][16+CW-1], r_vpos[0][16+CW-1:16]}
             - {r_vpos[1][16+CW-1], r_vpos[1][16+CW-1:16]};
        lpx  = ldx * ldx;
        lpy  = ldy * ldy;
        lsum = DW'(r_lsqx) + DW'(r_lsqy);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int v = 0; v < 3; v++) begin
                r_vpos[v] <= '0;
                r_col[v]  <= '0;
            end
            r_lsqx <= '0;
            r_lsqy <= '0;
            r_l2   <= '0;
            r_l8   <= '0;
            r_l9   <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (t_cfg_reg'(i_cfg_idx))
                    REG_VERTEX_A: r_vpos[0] <= i_cfg_data;
                    REG_VERTEX_B: r_vpos[1] <= i_cfg_data;
                    REG_VERTEX_C: r_vpos[2] <= i_cfg_data;
                    REG_COLOR_A:  r_col[0]  <= i_cfg_data[COLOR_W-1:0];
                    REG_COLOR_B:  r_col[1]  <= i_cfg_data[COLOR_W-1:0];
                    REG_COLOR_C:  r_col[2]  <= i_cfg_data[COLOR_W-1:0];
                    default: ;
                endcase
            end
            r_lsqx <= lpx[SQW-1:0];
            r_lsqy <= lpy[SQW-1:0];
            r_l2   <= lsum;
            r_l8   <= {lsum, 3'b000};
            r_l9   <= {lsum, 3'b000} + (DW+4)'(lsum);
        end
    end

    // pipeline control
    logic           en;
    logic [NST-1:0] r_vld;

    assign en            = !r_vld[NST-1] || o_color.ready;
    assign i_point.ready = en;
    assign o_color.valid = r_vld[NST-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NST-2:0], i_point.valid};
        end
    end

    // front: differences, squares, squared distance
    logic signed [CW:0]     r_dx [3], r_dy [3];
    logic signed [CW:0]     n_dx [3], n_dy [3];
    logic [SQW-1:0]         r_sx [3], r_sy [3];
    logic signed [2*CW+1:0] p_x  [3], p_y  [3];
    logic [DW-1:0]          r_d2 [3];
    logic                   r_big [3];
    logic [DW-1:0]          n_d2 [3];

    always_comb begin
        for (int v = 0; v < 3; v++) begin
            n_dx[v] = {r_vpos[v][CW-1], r_vpos[v][CW-1:0]}
                    - {i_point.point_x[CW-1], i_point.point_x[CW-1:0]};
            n_dy[v] = {r_vpos[v][16+CW-1], r_vpos[v][16+CW-1:16]}
                    - {i_point.point_y[CW-1], i_point.point_y[CW-1:0]};
            p_x[v]  = r_dx[v] * r_dx[v];
            p_y[v]  = r_dy[v] * r_dy[v];
            n_d2[v] = DW'(r_sx[v]) + DW'(r_sy[v]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int v = 0; v < 3; v++) begin
                r_dx[v]  <= n_dx[v];
                r_dy[v]  <= n_dy[v];
                r_sx[v]  <= p_x[v][SQW-1:0];
                r_sy[v]  <= p_y[v][SQW-1:0];
                r_d2[v]  <= n_d2[v];
                r_big[v] <= (DW+4)'(n_d2[v]) >= r_l9;
            end
        end
    end

    // restoring divider, one quotient bit per stage: q = floor(d2 * 2^(2F) / l2)
    logic [RW-1:0] r_drem [QW][3];
    logic [QW-1:0] r_dq   [QW][3];
    logic          r_dbig [QW][3];
    logic [RW-1:0] n_drem [QW][3];
    logic [QW-1:0] n_dq   [QW][3];
    logic          n_dbig [QW][3];

    always_comb begin
        logic [RW-1:0] src_rem;
        logic [QW-1:0] src_q;
        logic          ge;
        for (int k = 0; k < QW; k++) begin
            for (int v = 0; v < 3; v++) begin
                if (k == 0) begin
                    src_rem      = RW'(r_d2[v]);
                    src_q        = '0;
                    n_dbig[k][v] = r_big[v];
                end else begin
                    src_rem      = r_drem[k-1][v];
                    src_q        = r_dq[k-1][v];
                    n_dbig[k][v] = r_dbig[k-1][v];
                end
                ge = src_rem >= RW'(r_l8);
                if (ge) begin
                    src_rem = src_rem - RW'(r_l8);
                end
                n_drem[k][v] = {src_rem[RW-2:0], 1'b0};
                n_dq[k][v]   = {src_q[QW-2:0], ge};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_drem <= n_drem;
            r_dq   <= n_dq;
            r_dbig <= n_dbig;
        end
    end

    // digit-by-digit square root, one root bit per stage
    logic [SW-1:0] r_srem  [SW][3];
    logic [SW-1:0] r_root  [SW][3];
    logic [QW-1:0] r_rest  [SW][3];
    logic          r_sbig  [SW][3];
    logic [SW-1:0] n_srem  [SW][3];
    logic [SW-1:0] n_root  [SW][3];
    logic [QW-1:0] n_rest  [SW][3];
    logic          n_sbig  [SW][3];

    always_comb begin
        logic [SW-1:0] s_rem;
        logic [SW-1:0] s_root;
        logic [QW-1:0] s_rest;
        logic [SW+1:0] cur;
        logic [SW+1:0] trial;
        logic          ge;
        for (int j = 0; j < SW; j++) begin
            for (int v = 0; v < 3; v++) begin
                if (j == 0) begin
                    s_rem        = '0;
                    s_root       = '0;
                    s_rest       = r_dq[QW-1][v];
                    n_sbig[j][v] = r_dbig[QW-1][v];
                end else begin
                    s_rem        = r_srem[j-1][v];
                    s_root       = r_root[j-1][v];
                    s_rest       = r_rest[j-1][v];
                    n_sbig[j][v] = r_sbig[j-1][v];
                end
                cur   = {s_rem, s_rest[QW-1:QW-2]};
                trial = {s_root, 2'b01};
                ge    = cur >= trial;
                if (ge) begin
                    cur = cur - trial;
                end
                n_srem[j][v] = cur[SW-1:0];
                n_root[j][v] = {s_root[SW-2:0], ge};
                n_rest[j][v] = {s_rest[QW-3:0], 2'b00};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_srem <= n_srem;
            r_root <= n_root;
            r_rest <= n_rest;
            r_sbig <= n_sbig;
        end
    end

    // weight, products, channel sums, saturation
    logic signed [WW-1:0]  r_w   [3];
    logic signed [PW-1:0]  r_prod [3][3];
    logic signed [SMW-1:0] r_sum [3];
    logic signed [PW-1:0]  n_prod [3][3];
    logic signed [SMW-1:0] n_sum [3];
    logic [CHAN_W-1:0]     n_chan [3];
    logic                  n_clip;
    logic [CHAN_W-1:0]     r_chan [3];
    logic                  r_clip;
    logic                  r_degen;

    always_comb begin
        logic [SMW-F-1:0] hi;
        for (int v = 0; v < 3; v++) begin
            for (int c = 0; c < 3; c++) begin
                n_prod[v][c] = $signed({1'b0, r_col[v][8*c +: 8]}) * r_w[v];
            end
        end
        for (int c = 0; c < 3; c++) begin
            n_sum[c] = SMW'(r_prod[0][c]) + SMW'(r_prod[1][c]) + SMW'(r_prod[2][c]);
        end
        n_clip = 1'b0;
        for (int c = 0; c < 3; c++) begin
            hi = r_sum[c][SMW-1:F];
            if (r_sum[c][SMW-1]) begin
                n_chan[c] = '0;
                n_clip    = 1'b1;
            end else if (hi > (SMW-F)'(255)) begin
                n_chan[c] = '1;
                n_clip    = 1'b1;
            end else begin
                n_chan[c] = hi[CHAN_W-1:0];
            end
        end
        if (r_l2 == '0) begin
            for (int c = 0; c < 3; c++) begin
                n_chan[c] = '0;
            end
            n_clip = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int v = 0; v < 3; v++) begin
                r_w[v] <= r_sbig[SW-1][v] ? W_MIN : W_ONE - $signed({1'b0, r_root[SW-1][v]});
            end
            r_prod  <= n_prod;
            r_sum   <= n_sum;
            r_chan  <= n_chan;
            r_clip  <= n_clip;
            r_degen <= (r_l2 == '0);
        end
    end

    assign o_color.red        = r_chan[0];
    assign o_color.green      = r_chan[1];
    assign o_color.blue       = r_chan[2];
    assign o_color.clipped    = r_clip;
    assign o_color.degenerate = r_degen;

    logic out_black;

    assign out_black = ({o_color.red, o_color.green, o_color.blue, o_color.clipped} == '0);

    `TDCB_ASSERT_IMP(a_degen_black, o_color.valid && o_color.degenerate, out_black)
    `TDCB_ASSERT_NEXT(a_stall_holds, !en, $stable(r_vld))
    `TDCB_ASSERT_NEXT(a_accept_enters, i_point.valid && i_point.ready, r_vld[0])
    `TDCB_ASSERT_IMP(a_ready_when_empty, !o_color.valid, i_point.ready)

endmodule

FILE: tb/triangle_distance_color_blend_core_tb.sv
`timescale 1ns / 100ps

module triangle_distance_color_blend_core_tb;
    import tdcb_pkg::*;

    localparam int FRAC = 14;
    localparam int DRAIN_CYCLES = 70;
    localparam int CYCLE_LIMIT = 400000;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

    typedef struct {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       clipped;
        logic       degenerate;
    } t_color;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    tdcb_point_if pt ();
    tdcb_color_if col ();

    triangle_distance_color_blend_core uut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_point   (pt),
        .o_color   (col),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data)
    );

    logic [31:0] vert_pos[3];
    logic [23:0] vert_color[3];
    t_color expected_colors[$];
    int fail_count = 0;
    int cycle_count = 0;
    bit no_idle = 1'b0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    initial begin
        pt.valid = 1'b0;
        pt.point_x = '0;
        pt.point_y = '0;
        col.ready = 1'b0;
    end

    always @(negedge i_clk) begin
        col.ready <= no_idle || ($urandom_range(0, 99) >= 11);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("** triangle_distance_color_blend_core: FAILED **");
            $finish;
        end
    end

    function automatic longint unsigned sq_len(longint ax, longint ay, longint bx, longint by);
        longint dx;
        longint dy;
        dx = ax - bx;
        dy = ay - by;
        return longint'(dx * dx + dy * dy);
    endfunction

    function automatic longint unsigned floor_sqrt(longint unsigned n);
        longint unsigned r;
        r = 0;
        for (int b = 31; b >= 0; b--) begin
            if ((r | (64'd1 << b)) * (r | (64'd1 << b)) <= n)
                r = r | (64'd1 << b);
        end
        return r;
    endfunction

    function automatic longint blend_weight(longint unsigned d2, longint unsigned l2);
        longint one;
        longint w;
        one = longint'(1) << FRAC;
        if (d2 / l2 >= 9)
            return -2 * one;
        w = one - longint'(floor_sqrt((d2 << (2 * FRAC)) / l2));
        return (w < -2 * one) ? -2 * one : w;
    endfunction

    function automatic t_color blend_color(logic signed [15:0] px, logic signed [15:0] py);
        t_color c;
        longint vx[3];
        longint vy[3];
        longint w[3];
        longint sum;
        longint unsigned l2;
        logic [7:0] ch_val[3];
        c = '{8'd0, 8'd0, 8'd0, 1'b0, 1'b0};
        for (int v = 0; v < 3; v++) begin
            vx[v] = longint'($signed(vert_pos[v][15:0]));
            vy[v] = longint'($signed(vert_pos[v][31:16]));
        end
        l2 = sq_len(vx[0], vy[0], vx[1], vy[1]);
        if (l2 == 0) begin
            c.degenerate = 1'b1;
            return c;
        end
        for (int v = 0; v < 3; v++)
            w[v] = blend_weight(sq_len(vx[v], vy[v], longint'(px), longint'(py)), l2);
        for (int ch = 0; ch < 3; ch++) begin
            sum = 0;
            for (int v = 0; v < 3; v++)
                sum += longint'(vert_color[v][8*ch +: 8]) * w[v];
            if (sum < 0) begin
                ch_val[ch] = 8'd0;
                c.clipped = 1'b1;
            end else if ((sum >>> FRAC) > 255) begin
                ch_val[ch] = 8'd255;
                c.clipped = 1'b1;
            end else begin
                ch_val[ch] = 8'(sum >>> FRAC);
            end
        end
        c.red = ch_val[0];
        c.green = ch_val[1];
        c.blue = ch_val[2];
        return c;
    endfunction

    always @(posedge i_clk) begin
        t_color exp_c;
        if (i_rst_n && col.valid && col.ready) begin
            if (expected_colors.size() == 0) begin
                $error("unexpected color result");
                fail_count++;
            end else begin
                exp_c = expected_colors.pop_front();
                if (col.red !== exp_c.red) begin
                    $error("red: expected %0d, got %0d", exp_c.red, col.red);
                    fail_count++;
                end
                if (col.green !== exp_c.green) begin
                    $error("green: expected %0d, got %0d", exp_c.green, col.green);
                    fail_count++;
                end
                if (col.blue !== exp_c.blue) begin
                    $error("blue: expected %0d, got %0d", exp_c.blue, col.blue);
                    fail_count++;
                end
                if (col.clipped !== exp_c.clipped) begin
                    $error("clipped: expected %0d, got %0d", exp_c.clipped, col.clipped);
                    fail_count++;
                end
                if (col.degenerate !== exp_c.degenerate) begin
                    $error("degenerate: expected %0d, got %0d", exp_c.degenerate,
                           col.degenerate);
                    fail_count++;
                end
            end
        end
    end

    // called at a falling edge, returns at a falling edge with valid still high
    task automatic send_point(logic [15:0] x, logic [15:0] y);
        while (!no_idle && $urandom_range(0, 99) < 11) begin
            pt.valid <= 1'b0;
            @(negedge i_clk);
        end
        pt.valid <= 1'b1;
        pt.point_x <= x;
        pt.point_y <= y;
        do @(posedge i_clk); while (!pt.ready);
        expected_colors.push_back(blend_color(x, y));
        @(negedge i_clk);
    endtask

    task automatic wait_drain();
        pt.valid <= 1'b0;
        while (expected_colors.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx < 3)
            vert_pos[idx] = data;
        else if (idx < 6)
            vert_color[idx - 3] = data[23:0];
        @(negedge i_clk);
    endtask

    task automatic set_triangle(logic [31:0] a, logic [31:0] b, logic [31:0] c,
                                logic [23:0] ca, logic [23:0] cb, logic [23:0] cc);
        wait_drain();
        write_reg(REG_VERTEX_A, a);
        write_reg(REG_VERTEX_B, b);
        write_reg(REG_VERTEX_C, c);
        write_reg(REG_COLOR_A, {8'd0, ca});
        write_reg(REG_COLOR_B, {8'd0, cb});
        write_reg(REG_COLOR_C, {8'd0, cc});
    endtask

    function automatic logic [15:0] near_coord(logic [15:0] base);
        return base + 16'($signed($urandom_range(0, 1023)) - 512);
    endfunction

    task automatic test_degenerate();
        send_point(16'h0000, 16'h0000);
        send_point(16'h7FFF, 16'h8000);
        set_triangle(32'h0010_0010, 32'h0010_0010, 32'h0100_0000,
                     24'hFFFFFF, 24'h123456, 24'hABCDEF);
        send_point(16'h0010, 16'h0010);
        send_point(16'h8000, 16'h7FFF);
    endtask

    task automatic test_extremes();
        // saturation high: two coincident vertices weigh one on bright colors
        set_triangle(32'h0000_0000, 32'h0000_0001, 32'h0000_0000,
                     24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
        send_point(16'h0000, 16'h0000);
        send_point(16'h0001, 16'h0000);
        // weights pinned at minus two, sums go negative
        send_point(16'h7FFF, 16'h7FFF);
        send_point(16'h8000, 16'h8000);
        set_triangle(32'h8000_8000, 32'h7FFF_7FFF, 32'h7FFF_8000,
                     24'h0000FF, 24'h00FF00, 24'hFF0000);
        send_point(16'h8000, 16'h8000);
        send_point(16'h7FFF, 16'h7FFF);
        send_point(16'h0000, 16'h0000);
        send_point(16'h8000, 16'h7FFF);
        send_point(16'hFFFF, 16'h0001);
        set_triangle(32'h0000_FF00, 32'h0100_0100, 32'hFF80_0080,
                     24'h000000, 24'h808080, 24'h404040);
        send_point(16'h0000, 16'h0000);
        send_point(16'h0080, 16'h0080);
        send_point(16'h5555, 16'hAAAA);
        send_point(16'hAAAA, 16'h5555);
        // spare indexes must not disturb the triangle
        wait_drain();
        write_reg(REG_SPARE_6, 32'hFFFF_FFFF);
        write_reg(REG_SPARE_7, 32'h1234_5678);
        send_point(16'h0040, 16'h0040);
        send_point(16'h0100, 16'hFF00);
    endtask

    task automatic test_random();
        logic [31:0] pos[3];
        logic [15:0] x;
        logic [15:0] y;
        int pick;
        for (int phase = 0; phase < 12; phase++) begin
            for (int v = 0; v < 3; v++) begin
                if (phase < 4)
                    pos[v] = $urandom();
                else
                    pos[v] = {near_coord(16'h0000), near_coord(16'h0000)};
            end
            if (phase == 7)
                pos[1] = pos[0];
            set_triangle(pos[0], pos[1], pos[2], 24'($urandom()), 24'($urandom()),
                         24'($urandom()));
            no_idle = (phase == 5);
            for (int n = 0; n < 85; n++) begin
                pick = $urandom_range(0, 9);
                if (pick < 6) begin
                    x = near_coord(pos[pick % 3][15:0]);
                    y = near_coord(pos[pick % 3][31:16]);
                end else begin
                    x = 16'($urandom());
                    y = 16'($urandom());
                end
                if (n == 40 && phase == 2)
                    wait_drain();
                send_point(x, y);
            end
        end
        no_idle = 1'b0;
    endtask

    initial begin
        for (int v = 0; v < 3; v++) begin
            vert_pos[v] = '0;
            vert_color[v] = '0;
        end
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_degenerate();
        test_extremes();
        test_random();
        pt.valid <= 1'b0;
        while (expected_colors.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0)
            $display("** triangle_distance_color_blend_core: PASSED **");
        else
            $display("** triangle_distance_color_blend_core: FAILED **");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/tdcb_pkg.sv
hw/rtl/tdcb_point_if.sv
hw/rtl/tdcb_color_if.sv
hw/rtl/triangle_distance_color_blend_core.sv
tb/triangle_distance_color_blend_core_tb.sv
